/* sv/mcsp_pkg.sv */
// Package for the multicycle simple processor: sizes, command and opcode
// codes, and the command/status structs between controller and datapath.
// No dependencies.
package mcsp_pkg;

  localparam int MEM_WORDS = 4096;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int RF_DEPTH  = 6;

  localparam logic [2:0] CMD_WRITE = 3'd0;
  localparam logic [2:0] CMD_READ  = 3'd1;
  localparam logic [2:0] CMD_START = 3'd2;
  localparam logic [2:0] CMD_STEP  = 3'd3;
  localparam logic [2:0] CMD_REGRD = 3'd4;

  localparam logic [4:0] OPC_ADD = 5'd0;
  localparam logic [4:0] OPC_SUB = 5'd1;
  localparam logic [4:0] OPC_LSF = 5'd2;
  localparam logic [4:0] OPC_RSF = 5'd3;
  localparam logic [4:0] OPC_AND = 5'd4;
  localparam logic [4:0] OPC_OR  = 5'd5;
  localparam logic [4:0] OPC_XOR = 5'd6;
  localparam logic [4:0] OPC_LHI = 5'd7;
  localparam logic [4:0] OPC_LD  = 5'd8;
  localparam logic [4:0] OPC_ST  = 5'd9;
  localparam logic [4:0] OPC_JLT = 5'd16;
  localparam logic [4:0] OPC_JLE = 5'd17;
  localparam logic [4:0] OPC_JEQ = 5'd18;
  localparam logic [4:0] OPC_JNE = 5'd19;
  localparam logic [4:0] OPC_JIN = 5'd20;
  localparam logic [4:0] OPC_HLT = 5'd24;

  localparam logic [2:0] REG_ZERO = 3'd0;
  localparam logic [2:0] REG_IMM  = 3'd1;
  localparam logic [2:0] REG_LINK = 3'd7;

  typedef enum logic [1:0] {
    ASEL_CMD = 2'd0,
    ASEL_PC  = 2'd1,
    ASEL_OPB = 2'd2
  } asel_t;

  typedef enum logic [1:0] {
    RSEL_REQ  = 2'd0,
    RSEL_SRC0 = 2'd1,
    RSEL_SRC1 = 2'd2,
    RSEL_DST  = 2'd3
  } rsel_t;

  typedef struct packed {
    logic  take_in;
    logic  mem_rd;
    logic  mem_wr;
    asel_t mem_asel;
    logic  rf_rd;
    rsel_t rf_rsel;
    logic  ld_inst;
    logic  ld_a;
    logic  ld_b;
    logic  ld_d;
    logic  retire;
    logic  start;
    logic  ld_out;
  } ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       run;
    logic [4:0] opc;
  } sts_t;

endpackage

/* sv/mcsp_ctrl.sv */
// Controller of the multicycle simple processor: one-hot sequencer that
// walks each command through dispatch, and a step of a running machine on
// through fetch, operand reads and execute. Depends on mcsp_pkg.
module mcsp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  mcsp_pkg::sts_t sts,
  output mcsp_pkg::ctl_t ctl
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DISP   = 9'b000000010,
    S_DECODE = 9'b000000100,
    S_RDA    = 9'b000001000,
    S_RDB    = 9'b000010000,
    S_RDD    = 9'b000100000,
    S_EXEC   = 9'b001000000,
    S_WB     = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.take_in = 1'b1;
          state_next  = S_DISP;
        end
      end
      S_DISP: begin
        state_next = S_DONE;
        case (sts.cmd)
          mcsp_pkg::CMD_WRITE: begin
            ctl.mem_wr   = 1'b1;
            ctl.mem_asel = mcsp_pkg::ASEL_CMD;
          end
          mcsp_pkg::CMD_READ: begin
            ctl.mem_rd   = 1'b1;
            ctl.mem_asel = mcsp_pkg::ASEL_CMD;
          end
          mcsp_pkg::CMD_START: begin
            ctl.start = 1'b1;
          end
          mcsp_pkg::CMD_STEP: begin
            if (sts.run) begin
              ctl.mem_rd   = 1'b1;
              ctl.mem_asel = mcsp_pkg::ASEL_PC;
              state_next   = S_DECODE;
            end
          end
          mcsp_pkg::CMD_REGRD: begin
            ctl.rf_rd   = 1'b1;
            ctl.rf_rsel = mcsp_pkg::RSEL_REQ;
          end
          default: begin
          end
        endcase
      end
      S_DECODE: begin
        ctl.ld_inst = 1'b1;
        state_next  = S_RDA;
      end
      S_RDA: begin
        ctl.rf_rd   = 1'b1;
        ctl.rf_rsel = mcsp_pkg::RSEL_SRC0;
        state_next  = S_RDB;
      end
      S_RDB: begin
        ctl.ld_a    = 1'b1;
        ctl.rf_rd   = 1'b1;
        ctl.rf_rsel = mcsp_pkg::RSEL_SRC1;
        state_next  = S_RDD;
      end
      S_RDD: begin
        ctl.ld_b    = 1'b1;
        ctl.rf_rd   = 1'b1;
        ctl.rf_rsel = mcsp_pkg::RSEL_DST;
        state_next  = S_EXEC;
      end
      S_EXEC: begin
        ctl.ld_d     = 1'b1;
        ctl.mem_asel = mcsp_pkg::ASEL_OPB;
        ctl.mem_rd   = (sts.opc == mcsp_pkg::OPC_LD);
        ctl.mem_wr   = (sts.opc == mcsp_pkg::OPC_ST);
        state_next   = S_WB;
      end
      S_WB: begin
        ctl.retire = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // The result register is reloaded in the same cycle its old beat leaves.
        if (out_free) begin
          ctl.ld_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.ld_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DISP))
    else $error("accepted beat did not enter dispatch");

  a_result_posted: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (out_valid && state == S_IDLE))
    else $error("finished command did not post a result beat");

  a_decode_after_fetch: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECODE) |-> ($past(state) == S_DISP && $past(sts.run)))
    else $error("decode entered without a fetch");

endmodule

/* sv/mcsp_dpath.sv */
// Datapath of the multicycle simple processor: word memory, register file,
// pc, run flag, ALU, jump logic and result register. Depends on mcsp_pkg.
module mcsp_dpath (
  input  logic           clk,
  input  logic           rst,
  input  mcsp_pkg::ctl_t ctl,
  output mcsp_pkg::sts_t sts,
  input  logic [2:0]     cmd,
  input  logic [15:0]    address,
  input  logic [31:0]    write_data,
  input  logic [2:0]     reg_index,
  output logic [31:0]    read_data,
  output logic [15:0]    pc_value,
  output logic           running,
  output logic [4:0]     executed_opcode,
  output logic           jump_taken
);

  // Captured request.
  logic [2:0]  req_cmd;
  logic [15:0] req_addr;
  logic [31:0] req_wdata;
  logic [2:0]  req_ridx;

  // Architectural state.
  logic [15:0] pc;
  logic        run;

  // Instruction and operands.
  logic [31:0] inst;
  logic [31:0] opa, opb, opd;
  logic [4:0]  res_opc;
  logic        res_jmp;

  // Word memory.
  logic [31:0]              mem [mcsp_pkg::MEM_WORDS];
  logic [31:0]              mem_q;
  logic                     mem_ok_q;
  logic [31:0]              mem_full;
  logic                     mem_in_range;
  logic [mcsp_pkg::MEM_AW-1:0] mem_idx;
  logic [31:0]              mem_wd;
  logic [31:0]              mem_data;

  // Register file r2..r7.
  logic [31:0]                rf_mem [mcsp_pkg::RF_DEPTH];
  logic [mcsp_pkg::RF_DEPTH-1:0] rf_vld;
  logic [31:0]                rf_q;
  logic [2:0]                 rf_ridx;
  logic [2:0]                 rf_rslot;
  logic                       wb_en;
  logic [2:0]                 wb_idx;
  logic [2:0]                 wb_slot;
  logic [31:0]                wb_data;

  // Instruction fields.
  logic [4:0]  f_opc;
  logic [2:0]  f_dst, f_src0, f_src1;
  logic [31:0] f_imm;

  logic [31:0] alu_res;
  logic        take;
  logic [15:0] target;
  logic [31:0] rd_result;

  assign f_opc  = inst[29:25];
  assign f_dst  = inst[24:22];
  assign f_src0 = inst[21:19];
  assign f_src1 = inst[18:16];
  assign f_imm  = {{16{inst[15]}}, inst[15:0]};

  assign sts.cmd = req_cmd;
  assign sts.run = run;
  assign sts.opc = f_opc;

  // Register 0 reads as zero and register 1 as the immediate.
  function automatic logic [31:0] resolve(input logic [2:0] idx, input logic [31:0] imm,
                                          input logic [31:0] rv);
    logic [31:0] v;
    if (idx == mcsp_pkg::REG_ZERO) begin
      v = '0;
    end else if (idx == mcsp_pkg::REG_IMM) begin
      v = imm;
    end else begin
      v = rv;
    end
    return v;
  endfunction

  // Memory address and data selection.
  always_comb begin
    case (ctl.mem_asel)
      mcsp_pkg::ASEL_CMD: mem_full = {16'd0, req_addr};
      mcsp_pkg::ASEL_PC:  mem_full = {16'd0, pc};
      mcsp_pkg::ASEL_OPB: mem_full = opb;
      default:            mem_full = opb;
    endcase
    mem_in_range = (mem_full < 32'(mcsp_pkg::MEM_WORDS));
    mem_idx      = mem_full[mcsp_pkg::MEM_AW-1:0];
    mem_wd       = (ctl.mem_asel == mcsp_pkg::ASEL_CMD) ? req_wdata : opa;
  end

  assign mem_data = mem_ok_q ? mem_q : '0;

  always_ff @(posedge clk) begin
    if (ctl.mem_wr && mem_in_range) begin
      mem[mem_idx] <= mem_wd;
    end
    if (ctl.mem_rd) begin
      mem_q    <= mem[mem_idx];
      mem_ok_q <= mem_in_range;
    end
  end

  // Register file read.
  always_comb begin
    case (ctl.rf_rsel)
      mcsp_pkg::RSEL_REQ:  rf_ridx = req_ridx;
      mcsp_pkg::RSEL_SRC0: rf_ridx = f_src0;
      mcsp_pkg::RSEL_SRC1: rf_ridx = f_src1;
      mcsp_pkg::RSEL_DST:  rf_ridx = f_dst;
      default:             rf_ridx = f_dst;
    endcase
    rf_rslot = rf_ridx - 3'd2;
  end

  // Execute: ALU, jump condition and write-back selection.
  always_comb begin
    alu_res = '0;
    take    = 1'b0;
    target  = inst[15:0];
    case (f_opc)
      mcsp_pkg::OPC_ADD: alu_res = opa + opb;
      mcsp_pkg::OPC_SUB: alu_res = opa - opb;
      mcsp_pkg::OPC_LSF: alu_res = opa << opb[4:0];
      mcsp_pkg::OPC_RSF: alu_res = 32'($signed(opa) >>> opb[4:0]);
      mcsp_pkg::OPC_AND: alu_res = opa & opb;
      mcsp_pkg::OPC_OR:  alu_res = opa | opb;
      mcsp_pkg::OPC_XOR: alu_res = opa ^ opb;
      mcsp_pkg::OPC_LHI: alu_res = {inst[15:0], opd[15:0]};
      mcsp_pkg::OPC_LD:  alu_res = mem_data;
      mcsp_pkg::OPC_JLT: take = ($signed(opa) < $signed(opb));
      mcsp_pkg::OPC_JLE: take = !($signed(opb) < $signed(opa));
      mcsp_pkg::OPC_JEQ: take = (opa == opb);
      mcsp_pkg::OPC_JNE: take = (opa != opb);
      mcsp_pkg::OPC_JIN: begin
        take   = 1'b1;
        target = opa[15:0];
      end
      default: begin
      end
    endcase

    // A taken jump saves the jump's own address in r7; jumps write nothing else.
    if (take) begin
      wb_en   = 1'b1;
      wb_idx  = mcsp_pkg::REG_LINK;
      wb_data = {16'd0, pc};
    end else begin
      wb_en   = (f_opc <= mcsp_pkg::OPC_LD);
      wb_idx  = f_dst;
      wb_data = alu_res;
    end
    wb_slot = wb_idx - 3'd2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_vld <= '0;
    end else if (ctl.retire && wb_en && wb_idx >= 3'd2) begin
      rf_vld[wb_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.retire && wb_en && wb_idx >= 3'd2) begin
      rf_mem[wb_slot] <= wb_data;
    end
    if (ctl.rf_rd) begin
      if (rf_ridx >= 3'd2) begin
        rf_q <= rf_vld[rf_rslot] ? rf_mem[rf_rslot] : '0;
      end else begin
        rf_q <= '0;
      end
    end
  end

  // Control state: pc and run flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= '0;
      run <= 1'b0;
    end else if (ctl.start) begin
      pc  <= '0;
      run <= 1'b1;
    end else if (ctl.retire) begin
      pc <= take ? target : pc + 16'd1;
      if (f_opc == mcsp_pkg::OPC_HLT) begin
        run <= 1'b0;
      end
    end
  end

  // Request capture, operand latches and per-command result fields.
  always_ff @(posedge clk) begin
    if (ctl.take_in) begin
      req_cmd   <= cmd;
      req_addr  <= address;
      req_wdata <= write_data;
      req_ridx  <= reg_index;
      res_opc   <= '0;
      res_jmp   <= 1'b0;
    end
    if (ctl.ld_inst) begin
      inst <= mem_data;
    end
    if (ctl.ld_a) begin
      opa <= resolve(f_src0, f_imm, rf_q);
    end
    if (ctl.ld_b) begin
      opb <= resolve(f_src1, f_imm, rf_q);
    end
    if (ctl.ld_d) begin
      opd <= resolve(f_dst, f_imm, rf_q);
    end
    if (ctl.retire) begin
      res_opc <= f_opc;
      res_jmp <= take;
    end
  end

  always_comb begin
    case (req_cmd)
      mcsp_pkg::CMD_READ:  rd_result = mem_data;
      mcsp_pkg::CMD_REGRD: rd_result = (req_ridx >= 3'd2) ? rf_q : '0;
      default:             rd_result = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_out) begin
      read_data       <= rd_result;
      pc_value        <= pc;
      running         <= run;
      executed_opcode <= res_opc;
      jump_taken      <= res_jmp;
    end
  end

  a_start_state: assert property (@(posedge clk) disable iff (rst)
    ctl.start |=> (run && pc == 16'd0))
    else $error("start did not reset pc and set run");

  a_halt_stops: assert property (@(posedge clk) disable iff (rst)
    (ctl.retire && f_opc == mcsp_pkg::OPC_HLT) |=> !run)
    else $error("halt did not clear run");

  a_jump_link: assert property (@(posedge clk) disable iff (rst)
    (ctl.retire && take) |=> (rf_vld[3'd5] && rf_mem[3'd5] == {16'd0, $past(pc)}
                              && pc == $past(target)))
    else $error("taken jump did not link r7 or load target");

endmodule

/* sv/multicycle_simple_processor_unit.sv */
// Multicycle simple processor: top level joining controller and datapath.
// A step of a running machine goes from accepted beat to result beat through dispatch
// and fetch, decode, three operand reads, execute, write-back and result; every other
// command, a step while stopped included, goes through dispatch and result only. One
// command is in flight: the next beat is taken after the result is loaded, later if stalled.
// Reset clears pc, run flag and registers r2..r7; memory is undefined until written.
module multicycle_simple_processor_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [15:0] address,
  input  logic [31:0] write_data,
  input  logic [2:0]  reg_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_data,
  output logic [15:0] pc_value,
  output logic        running,
  output logic [4:0]  executed_opcode,
  output logic        jump_taken
);

  mcsp_pkg::ctl_t ctl;
  mcsp_pkg::sts_t sts;

  mcsp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  mcsp_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .sts             (sts),
    .cmd             (cmd),
    .address         (address),
    .write_data      (write_data),
    .reg_index       (reg_index),
    .read_data       (read_data),
    .pc_value        (pc_value),
    .running         (running),
    .executed_opcode (executed_opcode),
    .jump_taken      (jump_taken)
  );

endmodule

/* sim/mcsp_status_checker.sv */
// Checker for the multicycle simple processor: watches both channels, keeps its
// own copy of registers, pc, run flag and memory, and compares every result beat.
// Depends on mcsp_pkg for sizes, command codes, opcodes and register indexes.
module mcsp_status_checker
  import mcsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [15:0] address,
  input  logic [31:0] write_data,
  input  logic [2:0]  reg_index,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] read_data,
  input  logic [15:0] pc_value,
  input  logic        running,
  input  logic [4:0]  executed_opcode,
  input  logic        jump_taken,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] read_data;
    logic [15:0] pc_value;
    logic        running;
    logic [4:0]  opcode;
    logic        jumped;
  } status_t;

  logic [31:0] gpr [2:7];
  logic [15:0] pc_q;
  logic        run_q;
  logic [31:0] mem [0:MEM_WORDS-1];
  status_t     expected_status [$];

  function automatic logic [31:0] mem_word(input logic [31:0] addr);
    return (addr < MEM_WORDS) ? mem[addr[MEM_AW-1:0]] : '0;
  endfunction

  // r0 is zero and r1 stands for the immediate of the current instruction.
  function automatic logic [31:0] operand(input logic [2:0] idx, input logic [31:0] imm);
    case (idx)
      REG_ZERO: return '0;
      REG_IMM:  return imm;
      default:  return gpr[idx];
    endcase
  endfunction

  function automatic void write_gpr(input logic [2:0] idx, input logic [31:0] v);
    if (idx != REG_ZERO && idx != REG_IMM) gpr[idx] = v;
  endfunction

  function automatic status_t predict_status(input logic [2:0] c, input logic [15:0] a_in,
                                             input logic [31:0] d_in, input logic [2:0] r_in);
    status_t            s;
    logic [31:0]        inst, imm, a, b, held;
    logic signed [31:0] sa;
    logic [15:0]        nxt, target;
    logic               take;
    logic [4:0]         opc;
    logic [2:0]         dst, s0, s1;
    s = '0;
    case (c)
      CMD_WRITE: if (a_in < MEM_WORDS) mem[a_in[MEM_AW-1:0]] = d_in;
      CMD_READ:  s.read_data = mem_word({16'd0, a_in});
      CMD_START: begin
        pc_q = '0;
        run_q = 1'b1;
      end
      CMD_STEP: if (run_q) begin
        inst = mem_word({16'd0, pc_q});
        opc = inst[29:25];
        dst = inst[24:22];
        s0 = inst[21:19];
        s1 = inst[18:16];
        imm = {{16{inst[15]}}, inst[15:0]};
        a = operand(s0, imm);
        b = operand(s1, imm);
        nxt = pc_q + 16'd1;
        take = 1'b0;
        target = inst[15:0];
        case (opc)
          OPC_ADD: write_gpr(dst, a + b);
          OPC_SUB: write_gpr(dst, a - b);
          OPC_LSF: write_gpr(dst, a << b[4:0]);
          OPC_RSF: begin
            sa = a;
            write_gpr(dst, sa >>> b[4:0]);
          end
          OPC_AND: write_gpr(dst, a & b);
          OPC_OR:  write_gpr(dst, a | b);
          OPC_XOR: write_gpr(dst, a ^ b);
          OPC_LHI: begin
            held = operand(dst, imm);
            write_gpr(dst, {inst[15:0], held[15:0]});
          end
          OPC_LD:  write_gpr(dst, mem_word(b));
          OPC_ST:  if (b < MEM_WORDS) mem[b[MEM_AW-1:0]] = a;
          OPC_JLT: take = $signed(a) < $signed(b);
          OPC_JLE: take = $signed(a) <= $signed(b);
          OPC_JEQ: take = (a == b);
          OPC_JNE: take = (a != b);
          OPC_JIN: begin
            take = 1'b1;
            target = a[15:0];
          end
          OPC_HLT: run_q = 1'b0;
          default: ;
        endcase
        // A taken jump links the address of the jump itself, not the next one.
        if (take) begin
          gpr[REG_LINK] = {16'd0, pc_q};
          nxt = target;
        end
        pc_q = nxt;
        s.opcode = opc;
        s.jumped = take;
      end
      CMD_REGRD: s.read_data = operand(r_in, '0);
      default: ;
    endcase
    s.pc_value = pc_q;
    s.running = run_q;
    return s;
  endfunction

  always @(posedge clk) begin
    status_t want;
    int      errs;
    errs = 0;
    if (rst) begin
      for (int i = 2; i < 8; i++) gpr[i] = '0;
      pc_q = '0;
      run_q = 1'b0;
      expected_status.delete();
    end else begin
      // Retire the result beat first so that a stray beat never meets a fresh
      // expectation pushed at the same edge.
      if (out_valid && out_ready) begin
        if (expected_status.size() == 0) begin
          $error("result beat with nothing expected: read_data %h pc_value %h",
                 read_data, pc_value);
          errs++;
        end else begin
          want = expected_status.pop_front();
          if (read_data !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, read_data);
            errs++;
          end
          if (pc_value !== want.pc_value) begin
            $error("pc_value: expected %h, got %h", want.pc_value, pc_value);
            errs++;
          end
          if (running !== want.running) begin
            $error("running: expected %b, got %b", want.running, running);
            errs++;
          end
          if (executed_opcode !== want.opcode) begin
            $error("executed_opcode: expected %0d, got %0d", want.opcode, executed_opcode);
            errs++;
          end
          if (jump_taken !== want.jumped) begin
            $error("jump_taken: expected %b, got %b", want.jumped, jump_taken);
            errs++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_status.push_back(predict_status(cmd, address, write_data, reg_index));
    end
    pending_count <= expected_status.size();
    fail_count <= fail_count + errs;
  end

endmodule

/* sim/tb_top.sv */
// Testbench top for the multicycle simple processor: clock, reset, command
// stimulus with random idling on both channels, and the final verdict.
// Depends on mcsp_pkg, multicycle_simple_processor_unit and mcsp_status_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mcsp_pkg::*;

  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
  localparam logic [4:0] OPC_UNDEF       = 5'd10;
  localparam logic [2:0] R2 = 3'd2;
  localparam logic [2:0] R3 = 3'd3;
  localparam logic [2:0] R4 = 3'd4;
  localparam logic [2:0] R5 = 3'd5;
  localparam logic [2:0] R6 = 3'd6;

  localparam int BOOT_LEN     = 22;
  localparam int BOOT_STEPS   = 19;
  localparam int RANDOM_BEATS = 1250;
  localparam int PROG_SPAN    = 64;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int RUN_LIMIT    = 8_000_000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  cmd;
  logic [15:0] address;
  logic [31:0] write_data;
  logic [2:0]  reg_index;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] read_data;
  logic [15:0] pc_value;
  logic        running;
  logic [4:0]  executed_opcode;
  logic        jump_taken;
  int          fail_count;
  int          pending_count;
  logic        hold_request = 1'b0;
  logic [31:0] boot_prog [BOOT_LEN];

  multicycle_simple_processor_unit u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .cmd             (cmd),
    .address         (address),
    .write_data      (write_data),
    .reg_index       (reg_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .read_data       (read_data),
    .pc_value        (pc_value),
    .running         (running),
    .executed_opcode (executed_opcode),
    .jump_taken      (jump_taken)
  );

  mcsp_status_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .cmd             (cmd),
    .address         (address),
    .write_data      (write_data),
    .reg_index       (reg_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .read_data       (read_data),
    .pc_value        (pc_value),
    .running         (running),
    .executed_opcode (executed_opcode),
    .jump_taken      (jump_taken),
    .fail_count      (fail_count),
    .pending_count   (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    #(RUN_LIMIT);
    $display("Verification failed");
    $finish;
  end

  function automatic logic [31:0] encode(input logic [4:0] opc, input logic [2:0] dst,
                                         input logic [2:0] s0, input logic [2:0] s1,
                                         input logic [15:0] imm);
    return {2'b00, opc, dst, s0, s1, imm};
  endfunction

  // Mostly defined opcodes with small immediates, so that jumps and loads stay
  // in the low words where programs live; others hit the memory boundary or are random.
  function automatic logic [31:0] random_inst();
    logic [4:0]  opc;
    logic [15:0] imm;
    logic [2:0]  s1;
    logic [1:0]  spare;
    int          pick;
    if ($urandom_range(0, 99) < 85) begin
      case ($urandom_range(0, 15))
        0:  opc = OPC_ADD;
        1:  opc = OPC_SUB;
        2:  opc = OPC_LSF;
        3:  opc = OPC_RSF;
        4:  opc = OPC_AND;
        5:  opc = OPC_OR;
        6:  opc = OPC_XOR;
        7:  opc = OPC_LHI;
        8:  opc = OPC_LD;
        9:  opc = OPC_ST;
        10: opc = OPC_JLT;
        11: opc = OPC_JLE;
        12: opc = OPC_JEQ;
        13: opc = OPC_JNE;
        14: opc = OPC_JIN;
        default: opc = OPC_HLT;
      endcase
    end else begin
      opc = 5'($urandom());
    end
    pick = $urandom_range(0, 99);
    if (pick < 60) imm = 16'($urandom_range(0, PROG_SPAN - 1));
    else if (pick < 80) imm = 16'($urandom_range(MEM_WORDS - 8, MEM_WORDS + 8));
    else imm = 16'($urandom());
    s1 = ($urandom_range(0, 1) == 1) ? REG_IMM : 3'($urandom());
    spare = 2'($urandom());
    return {spare, opc, 3'($urandom()), 3'($urandom()), s1, imm};
  endfunction

  function automatic logic [15:0] random_addr();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 16'($urandom_range(0, PROG_SPAN - 1));
    if (pick < 80) return 16'($urandom_range(MEM_WORDS - 8, MEM_WORDS + 8));
    return 16'($urandom());
  endfunction

  // Offers one command beat and returns at the edge where it is accepted.
  task automatic send_beat(input logic [2:0] c, input logic [15:0] a, input logic [31:0] d,
                           input logic [2:0] r, input bit idle_ok);
    int gap;
    int pick;
    gap = 0;
    if (idle_ok) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) gap = 0;
      else if (pick < 88) gap = $urandom_range(1, 3);
      else if (pick < 96) gap = $urandom_range(4, 10);
      else gap = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    address <= a;
    write_data <= d;
    reg_index <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Result side: short stalls mostly, a few long ones, some stretches always
  // ready, and one long hold-off on request so the block backs up its input.
  initial begin : result_sink
    int pick;
    int span;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          out_ready <= 1'b1;
          span = $urandom_range(1, 8);
        end else if (pick < 90) begin
          out_ready <= 1'b0;
          span = $urandom_range(1, 3);
        end else if (pick < 95) begin
          out_ready <= 1'b0;
          span = $urandom_range(10, 40);
        end else begin
          out_ready <= 1'b1;
          span = $urandom_range(50, 150);
        end
        repeat (span) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int          pick;
    logic [31:0] word;
    rst <= 1'b1;
    in_valid <= 1'b0;
    cmd <= CMD_WRITE;
    address <= '0;
    write_data <= '0;
    reg_index <= REG_ZERO;

    // Boot program: every operation at least once, a write to r1 that must drop, a
    // shift amount above 31, stores and loads beyond memory, an undefined
    // opcode, jumps both taken and not, and a halt.
    boot_prog = '{
      encode(OPC_ADD, R2, REG_IMM, REG_ZERO, 16'hFFFF),
      encode(OPC_LHI, R3, REG_ZERO, REG_ZERO, 16'h8000),
      encode(OPC_RSF, R4, R3, REG_IMM, 16'd31),
      encode(OPC_LSF, R5, R2, REG_IMM, 16'd36),
      encode(OPC_SUB, R6, REG_ZERO, R2, 16'd0),
      encode(OPC_AND, R4, R5, R3, 16'd0),
      encode(OPC_OR, REG_IMM, R5, R6, 16'd0),
      encode(OPC_XOR, R6, R2, R3, 16'd0),
      encode(OPC_ST, REG_ZERO, R2, REG_IMM, 16'd100),
      encode(OPC_ST, REG_ZERO, R2, REG_IMM, 16'h7000),
      encode(OPC_LD, R4, REG_ZERO, REG_IMM, 16'd100),
      encode(OPC_LD, R5, REG_ZERO, R3, 16'd0),
      encode(OPC_UNDEF, R2, R2, R2, 16'd0),
      encode(OPC_JLT, REG_ZERO, R3, REG_ZERO, 16'd15),
      encode(OPC_HLT, REG_ZERO, REG_ZERO, REG_ZERO, 16'd0),
      encode(OPC_JLE, REG_ZERO, REG_ZERO, R3, 16'd0),
      encode(OPC_JEQ, REG_ZERO, REG_ZERO, REG_ZERO, 16'd18),
      encode(OPC_HLT, REG_ZERO, REG_ZERO, REG_ZERO, 16'd0),
      encode(OPC_JNE, REG_ZERO, REG_ZERO, REG_ZERO, 16'd0),
      encode(OPC_JIN, REG_ZERO, REG_IMM, REG_ZERO, 16'd21),
      encode(OPC_HLT, REG_ZERO, REG_ZERO, REG_ZERO, 16'd0),
      encode(OPC_HLT, REG_ZERO, REG_ZERO, REG_ZERO, 16'd0)
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Fill every memory word once, so no fetch, load or read can ever land
    // on a word that was never written.
    for (int w = 0; w < MEM_WORDS; w++) begin
      if (w < BOOT_LEN) word = boot_prog[w];
      else if (w == MEM_WORDS - 1) word = '1;
      else if ($urandom_range(0, 4) == 0) word = $urandom();
      else word = random_inst();
      send_beat(CMD_WRITE, 16'(w), word, REG_ZERO, 1'b0);
    end

    send_beat(CMD_STEP, '0, '0, REG_ZERO, 1'b1);
    send_beat(CMD_SPARE_LAST, 16'hFFFF, '1, REG_LINK, 1'b1);
    send_beat(CMD_REGRD, '0, '0, REG_IMM, 1'b1);
    send_beat(CMD_READ, 16'hFFFF, '0, REG_ZERO, 1'b1);
    send_beat(CMD_READ, 16'(MEM_WORDS - 1), '0, REG_ZERO, 1'b1);
    send_beat(CMD_START, '0, '0, REG_ZERO, 1'b1);
    // One step more than the program runs, so the last lands after the halt.
    repeat (BOOT_STEPS + 1) send_beat(CMD_STEP, '0, '0, REG_ZERO, 1'b1);
    send_beat(CMD_REGRD, '0, '0, REG_LINK, 1'b1);

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == HOLD_AT) hold_request = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 50)
        send_beat(CMD_STEP, 16'($urandom()), $urandom(), 3'($urandom()), 1'b1);
      else if (pick < 55)
        send_beat(CMD_START, 16'($urandom()), $urandom(), 3'($urandom()), 1'b1);
      else if (pick < 70)
        send_beat(CMD_WRITE, random_addr(),
                  ($urandom_range(0, 4) == 0) ? $urandom() : random_inst(),
                  3'($urandom()), 1'b1);
      else if (pick < 80)
        send_beat(CMD_READ, random_addr(), $urandom(), 3'($urandom()), 1'b1);
      else if (pick < 92)
        send_beat(CMD_REGRD, 16'($urandom()), $urandom(), 3'($urandom()), 1'b1);
      else if (pick < 95)
        send_beat(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)), 16'($urandom()),
                  $urandom(), 3'($urandom()), 1'b1);
      else
        send_beat(3'($urandom()), 16'($urandom()), $urandom(), 3'($urandom()), 1'b1);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
